### sv/assert_macros.svh
// Concurrent assertion macros shared by the tracker modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that cons holds in the same cycle as ante (clk, rst_n from the module).
`define MPCT_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that cons holds in the cycle after ante.
`define MPCT_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/mpct_pkg.sv
// Shared types, constants and helpers of the mouse packet cursor tracker.
package mpct_pkg;

    // Cursor coordinate width and its largest value
    localparam int COORD_W   = 12;
    localparam int COORD_MAX = (1 << COORD_W) - 1;

    // Configuration port
    localparam int CFG_W      = 13;
    localparam int CFG_ADDR_W = 2;

    localparam logic [CFG_ADDR_W-1:0] REG_SCREEN_WIDTH  = CFG_ADDR_W'(0);
    localparam logic [CFG_ADDR_W-1:0] REG_SCREEN_HEIGHT = CFG_ADDR_W'(1);

    // Header byte fields
    localparam logic [7:0] HDR_SYNC_MASK = 8'hC8;
    localparam logic [7:0] HDR_SYNC_VAL  = 8'h08;
    localparam int         HDR_X_SIGN    = 4;
    localparam int         HDR_Y_SIGN    = 5;

    // Motion widths
    localparam int DX_W = 9;
    localparam int DY_W = 10;

    // One complete packet passed from front to back
    typedef struct packed {
        logic [7:0] header;
        logic [7:0] x_byte;
        logic [7:0] y_byte;
    } pkt_t;

    // Turn a screen size into the largest coordinate allowed on that axis
    function automatic logic [COORD_W-1:0] size_to_limit(input logic [CFG_W-1:0] size);
        logic [CFG_W+COORD_W-1:0] wide;
        wide = (CFG_W + COORD_W)'(size) - (CFG_W + COORD_W)'(1);
        if (size == '0)
            return '0;
        else if (wide > (CFG_W + COORD_W)'(COORD_MAX))
            return COORD_W'(COORD_MAX);
        else
            return wide[COORD_W-1:0];
    endfunction

    localparam logic [COORD_W-1:0] RST_LIMIT_X = size_to_limit(CFG_W'(640));
    localparam logic [COORD_W-1:0] RST_LIMIT_Y = size_to_limit(CFG_W'(480));

endpackage

### sv/mpct_ifs.sv
// Handshake channel interfaces of the mouse packet cursor tracker.

// Mouse byte channel
interface mpct_in_if
    import mpct_pkg::*;
();
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

// Packet report channel
interface mpct_out_if
    import mpct_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic [2:0]                buttons;
    logic signed [DX_W-1:0]    delta_x;
    logic signed [DY_W-1:0]    delta_y;
    logic [COORD_W-1:0]        cursor_col;
    logic [COORD_W-1:0]        cursor_y;

    modport source (output valid, output buttons, output delta_x, output delta_y,
                    output cursor_col, output cursor_y, input ready);
    modport sink   (input valid, input buttons, input delta_x, input delta_y,
                    input cursor_col, input cursor_y, output ready);
endinterface

// Configuration write channel
interface mpct_cfg_if
    import mpct_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [CFG_ADDR_W-1:0] addr;
    logic [CFG_W-1:0]      data;

    modport source (output valid, output addr, output data, input ready);
    modport sink   (input valid, input addr, input data, output ready);
endinterface

### sv/mpct_front.sv
// Front end: byte framing, header sync check and packet assembly.
`include "assert_macros.svh"

module mpct_front
    import mpct_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    mpct_in_if.sink        mouse,
    output logic           push_valid,
    input  logic           push_ready,
    output pkt_t           push_data
);

    typedef enum logic [3:0] {
        PH_ACK  = 4'b0001,
        PH_HEAD = 4'b0010,
        PH_X    = 4'b0100,
        PH_Y    = 4'b1000
    } phase_t;

    phase_t     phase_reg, phase_next;
    logic [7:0] header_reg, header_next;
    logic [7:0] x_byte_reg, x_byte_next;
    logic       fire;

    // Stall only the last byte of a packet while the queue is full
    assign mouse.ready = (phase_reg != PH_Y) || push_ready;
    assign fire        = mouse.valid && mouse.ready;

    // Hand the finished packet to the queue with the last byte
    assign push_valid       = mouse.valid && (phase_reg == PH_Y);
    assign push_data.header = header_reg;
    assign push_data.x_byte = x_byte_reg;
    assign push_data.y_byte = mouse.rx_byte;

    // Advance the framing phase
    always_comb
    begin
        phase_next  = phase_reg;
        header_next = header_reg;
        x_byte_next = x_byte_reg;
        if (fire)
        begin
            unique case (phase_reg)
                PH_ACK:
                begin
                    phase_next = PH_HEAD;
                end
                PH_HEAD:
                begin
                    header_next = mouse.rx_byte;
                    if ((mouse.rx_byte & HDR_SYNC_MASK) == HDR_SYNC_VAL)
                        phase_next = PH_X;
                end
                PH_X:
                begin
                    x_byte_next = mouse.rx_byte;
                    phase_next  = PH_Y;
                end
                PH_Y:
                begin
                    phase_next = PH_HEAD;
                end
                default:
                begin
                    phase_next = PH_HEAD;
                end
            endcase
        end
    end

    // Hold phase and stored bytes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_ACK;
            header_reg <= '0;
            x_byte_reg <= '0;
        end
        else
        begin
            phase_reg  <= phase_next;
            header_reg <= header_next;
            x_byte_reg <= x_byte_next;
        end
    end

    // The acknowledge phase is left for good once passed
    `MPCT_ASSERT_NXT(a_no_ack_return, phase_reg != PH_ACK, phase_reg != PH_ACK,
                     "front returned to acknowledge phase")
    // Only a header with sync bit set and no overflow may open a packet
    `MPCT_ASSERT_NXT(a_header_sync, fire && phase_reg == PH_HEAD && phase_next == PH_X,
                     (header_reg & HDR_SYNC_MASK) == HDR_SYNC_VAL,
                     "packet opened on a bad header")

endmodule

### sv/mpct_queue.sv
// Two-entry packet queue between the front and back ends.
`include "assert_macros.svh"

module mpct_queue
    import mpct_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push_valid,
    output logic push_ready,
    input  pkt_t push_data,
    output logic pop_valid,
    input  logic pop_ready,
    output pkt_t pop_data
);

    pkt_t       mem_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       push_fire;
    logic       pop_fire;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign push_fire  = push_valid && push_ready;
    assign pop_fire   = pop_valid && pop_ready;

    // Advance pointers and fill count
    always_comb
    begin
        wr_ptr_next = push_fire ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop_fire ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push_fire) - 2'(pop_fire);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the pushed packet
    always_ff @(posedge clk)
    begin
        if (push_fire)
            mem_reg[wr_ptr_reg] <= push_data;
    end

    // A packet pushed into an empty queue is offered the next cycle
    `MPCT_ASSERT_NXT(a_push_visible, push_fire && count_reg == 2'd0, pop_valid,
                     "pushed packet not visible at queue head")

endmodule

### sv/mpct_back.sv
// Back end: motion decode, cursor clamp and report register.
`include "assert_macros.svh"

module mpct_back
    import mpct_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    pop_valid,
    output logic    pop_ready,
    input  pkt_t    pop_data,
    mpct_cfg_if.sink cfg,
    mpct_out_if.source report
);

    localparam int SUM_W = COORD_W + 3;

    logic [COORD_W-1:0]     limit_x_reg, limit_x_next;
    logic [COORD_W-1:0]     limit_y_reg, limit_y_next;
    logic [COORD_W-1:0]     pos_x_reg, pos_x_next;
    logic [COORD_W-1:0]     pos_y_reg, pos_y_next;
    logic                   out_valid_reg, out_valid_next;
    logic [2:0]             buttons_reg;
    logic signed [DX_W-1:0] dx_reg, dx;
    logic signed [DY_W-1:0] dy_reg, dy, dy_raw;
    logic                   pop_fire;

    // Add a motion to a coordinate and clamp to 0 .. limit
    function automatic logic [COORD_W-1:0] clamp_axis(
        input logic [COORD_W-1:0]     pos,
        input logic signed [DY_W-1:0] delta,
        input logic [COORD_W-1:0]     limit
    );
        logic signed [SUM_W-1:0] sum;
        sum = $signed({3'b000, pos}) + SUM_W'(delta);
        if (sum < 0)
            return '0;
        else if (sum > $signed({3'b000, limit}))
            return limit;
        else
            return sum[COORD_W-1:0];
    endfunction

    // Take a packet whenever the report register is free or being drained
    assign pop_ready = !out_valid_reg || report.ready;
    assign pop_fire  = pop_valid && pop_ready;
    assign cfg.ready = 1'b1;

    // Decode signed motion, negating y for screen direction
    always_comb
    begin
        dx     = $signed({pop_data.header[HDR_X_SIGN], pop_data.x_byte});
        dy_raw = $signed({pop_data.header[HDR_Y_SIGN], pop_data.header[HDR_Y_SIGN],
                          pop_data.y_byte});
        dy     = -dy_raw;
    end

    // Update cursor, limits and report valid
    always_comb
    begin
        pos_x_next     = pos_x_reg;
        pos_y_next     = pos_y_reg;
        limit_x_next   = limit_x_reg;
        limit_y_next   = limit_y_reg;
        out_valid_next = out_valid_reg && !report.ready;
        if (pop_fire)
        begin
            pos_x_next     = clamp_axis(pos_x_reg, DY_W'(dx), limit_x_reg);
            pos_y_next     = clamp_axis(pos_y_reg, dy, limit_y_reg);
            out_valid_next = 1'b1;
        end
        if (cfg.valid)
        begin
            unique case (cfg.addr)
                REG_SCREEN_WIDTH:  limit_x_next = size_to_limit(cfg.data);
                REG_SCREEN_HEIGHT: limit_y_next = size_to_limit(cfg.data);
                default:           ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_x_reg   <= RST_LIMIT_X;
            limit_y_reg   <= RST_LIMIT_Y;
            pos_x_reg     <= '0;
            pos_y_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            limit_x_reg   <= limit_x_next;
            limit_y_reg   <= limit_y_next;
            pos_x_reg     <= pos_x_next;
            pos_y_reg     <= pos_y_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Load the report payload
    always_ff @(posedge clk)
    begin
        if (pop_fire)
        begin
            buttons_reg <= pop_data.header[2:0];
            dx_reg      <= dx;
            dy_reg      <= dy;
        end
    end

    assign report.valid      = out_valid_reg;
    assign report.buttons    = buttons_reg;
    assign report.delta_x    = dx_reg;
    assign report.delta_y    = dy_reg;
    assign report.cursor_col = pos_x_reg;
    assign report.cursor_y   = pos_y_reg;

    // Check that a reported cursor does not lie beyond the screen limits
    `MPCT_ASSERT_IMP(a_cursor_bound, out_valid_reg,
                     pos_x_reg <= limit_x_reg && pos_y_reg <= limit_y_reg,
                     "cursor outside clamp limits")

endmodule

### sv/mouse_packet_cursor_tracker.sv
// Top level of the mouse packet cursor tracker.
//
//  channel | dir | payload                                         | accept
//  mouse   | in  | rx_byte[7:0]                                    | valid && ready
//  report  | out | buttons, delta_x, delta_y, cursor_col, cursor_y | valid && ready
//  cfg     | in  | addr[1:0] (0 width, 1 height), data[12:0]       | valid && ready
//
// One mouse byte is taken every cycle unless the front end stalls; a report follows
// the third byte of a packet through the queue stage, then the report register.
// The front end stalls only on the third byte while the two-entry queue is full.
// Reset clears framing, cursor and report state; the screen defaults to 640 x 480.
// cfg is always ready; a write to an unknown index is ignored.

module mouse_packet_cursor_tracker
    import mpct_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    mpct_in_if.sink    mouse,
    mpct_out_if.source report,
    mpct_cfg_if.sink   cfg
);

    logic push_valid;
    logic push_ready;
    pkt_t push_data;
    logic pop_valid;
    logic pop_ready;
    pkt_t pop_data;

    mpct_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .mouse      (mouse),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    mpct_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    mpct_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data),
        .cfg       (cfg),
        .report    (report)
    );

endmodule
